@@ hw/rtl/rcsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsfd_pkg: shared types and constants of the serial RC frame decoder
// Beat types, setup register layout, codes and the servo drive function.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsfd_pkg;

	localparam int FRAME_BYTES  = 23;
	localparam int FRAME_BITS   = FRAME_BYTES * 8;
	localparam int PACKED_CH    = 16;
	localparam int POS_BITS     = 11;
	localparam int DECODE_BITS  = PACKED_CH * POS_BITS + 2;
	localparam int PULSE_FIELDS = 4;

	localparam logic [7:0]  HEADER_BYTE   = 8'h0F;
	localparam logic [1:0]  GAP_TICKS     = 2'd2;
	localparam logic [1:0]  GAP_SAT       = 2'd3;
	localparam logic [4:0]  FRAME_LAST    = 5'(FRAME_BYTES);
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [8:0]  LED_ON_AT     = 9'd300;
	localparam logic [8:0]  LED_OFF_AT    = 9'd305;
	localparam logic signed [13:0] NEUTRAL_POS = 14'sd1023;
	localparam logic signed [13:0] POS_MAX     = 14'sd2047;
	localparam logic [11:0] PULSE_MIN     = 12'h800;
	localparam logic [11:0] PULSE_MAX     = 12'hFFF;
	localparam logic [11:0] PULSE_OFF     = 12'h000;

	localparam logic [4:0] CH_NONE  = 5'd0;
	localparam logic [4:0] CH_FIRST = 5'd1;
	localparam logic [4:0] CH_LAST  = 5'd16;
	localparam logic [4:0] CH_FLAG0 = 5'd17;
	localparam logic [4:0] CH_FLAG1 = 5'd18;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [2:0] REG_TIMEOUT = 3'd4;

	typedef enum logic [1:0] {
		FS_HOLD    = 2'd0,
		FS_OFF     = 2'd1,
		FS_NEUTRAL = 2'd2,
		FS_HOLD_HI = 2'd3
	} fs_mode_t;

	typedef struct packed {
		logic signed [11:0] subtrim;
		fs_mode_t           fs_mode;
		logic               reverse;
		logic [4:0]         channel;
	} servo_setup_t;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
		logic       rx_error;
	} in_item_t;

	typedef struct packed {
		logic [11:0] pulse_zero;
		logic [11:0] pulse_one;
		logic [11:0] pulse_two;
		logic [11:0] pulse_three;
		logic        outputs_loaded;
		logic        failsafe_on;
		logic        led_on;
	} out_item_t;

	function automatic logic [11:0] drive_pos(input logic signed [13:0] pos);
		logic [11:0] r;
		if (pos < 14'sd0)
			r = PULSE_MIN;
		else if (pos > POS_MAX)
			r = PULSE_MAX;
		else
			r = {1'b1, pos[10:0]};
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rcsfd_servo_lane.sv @@
// ----------------------------------------------------------------------------
// rcsfd_servo_lane: one servo output
// Decodes the selected channel, applies reverse, subtrim, clamp and failsafe.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_servo_lane
	import rcsfd_pkg::*;
(
	input  servo_setup_t            setup,
	input  logic [DECODE_BITS-1:0]  frame,
	input  logic [11:0]             pulse,
	input  logic                    fs_load,
	input  logic                    frame_load,
	output logic [11:0]             pulse_next
);

	logic [POS_BITS-1:0]  slot [PACKED_CH];
	logic [POS_BITS-1:0]  pos;
	logic [POS_BITS-1:0]  pos_r;
	logic [4:0]           ch_off;
	logic signed [13:0]   trim;
	logic signed [13:0]   sum;
	logic signed [13:0]   neutral;
	logic [11:0]          fs_pulse;

	for (genvar c = 0; c < PACKED_CH; c++) begin : g_slot
		assign slot[c] = frame[c*POS_BITS +: POS_BITS];
	end

	assign ch_off = setup.channel - CH_FIRST;

	always_comb begin
		if (setup.channel >= CH_FIRST && setup.channel <= CH_LAST)
			pos = slot[ch_off[3:0]];
		else if (setup.channel == CH_FLAG0)
			pos = {POS_BITS{frame[DECODE_BITS-2]}};
		else if (setup.channel == CH_FLAG1)
			pos = {POS_BITS{frame[DECODE_BITS-1]}};
		else
			pos = '0;
	end

	assign pos_r   = setup.reverse ? ~pos : pos;
	assign trim    = {{2{setup.subtrim[11]}}, setup.subtrim};
	assign sum     = $signed({3'b000, pos_r}) + trim;
	assign neutral = NEUTRAL_POS + trim;

	always_comb begin
		case (setup.fs_mode)
			FS_OFF:     fs_pulse = PULSE_OFF;
			FS_NEUTRAL: fs_pulse = drive_pos(neutral);
			default:    fs_pulse = pulse;
		endcase
	end

	always_comb begin
		pulse_next = fs_load ? fs_pulse : pulse;
		if (frame_load && setup.channel != CH_NONE)
			pulse_next = drive_pos(sum);
	end

endmodule

`default_nettype wire

@@ hw/rtl/rc_serial_frame_servo_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rc_serial_frame_servo_decoder_unit: serial RC frame decoder, four servos
// Frames UART bytes, tracks link loss and drives servo duty values.
// ----------------------------------------------------------------------------
// Each input beat is a received byte or a timer tick and yields exactly one
// result beat. The block takes one beat per clock while the output side is
// free: a beat lands in an input register, is decoded against the frame
// state there and its result is registered in the output register. The
// framer and link timer update their state together with the result, which
// sets that rate. While the consumer stalls a result, the input register
// takes one more beat and then in_ready stays low until the result is taken.
// Setup registers are to be written through the plain write port only
// while no beat is in flight: the user's duty, the block does not enforce it.
`default_nettype none

module rc_serial_frame_servo_decoder_unit
	import rcsfd_pkg::*;
#(
	parameter int SERVO_OUTPUTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [19:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	servo_setup_t          setup_q [SERVO_OUTPUTS];
	logic [15:0]           timeout_q;
	logic                  in_frame_q, in_frame_n;
	logic [4:0]            byte_cnt_q, byte_cnt_n;
	logic [FRAME_BITS-1:0] frame_q, frame_n;
	logic [1:0]            gap_q, gap_n;
	logic [15:0]           link_q, link_n;
	logic                  fs_q, fs_n;
	logic [11:0]           pulse_q [SERVO_OUTPUTS];
	logic [11:0]           pulse_n [SERVO_OUTPUTS];
	logic [8:0]            good_q, good_n, good_inc;
	logic                  led_q, led_n;

	in_item_t              item_s1;
	logic                  valid_s1;
	out_item_t             out_q;
	logic                  out_valid_q;

	logic                  advance;
	logic                  frame_done;
	logic                  fs_load;
	logic [11:0]           pulse_field [PULSE_FIELDS];

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		in_frame_n = in_frame_q;
		byte_cnt_n = byte_cnt_q;
		frame_n    = frame_q;
		gap_n      = gap_q;
		link_n     = link_q;
		frame_done = 1'b0;
		if (item_s1.command == CMD_TICK) begin
			gap_n  = (gap_q == GAP_SAT) ? GAP_SAT : gap_q + 2'd1;
			link_n = (link_q != 16'd0) ? link_q - 16'd1 : link_q;
		end else begin
			gap_n = 2'd0;
			if (item_s1.rx_error) begin
				in_frame_n = 1'b0;
			end else if (in_frame_q) begin
				if (byte_cnt_q >= FRAME_LAST) begin
					in_frame_n = 1'b0;
					frame_done = 1'b1;
					link_n     = timeout_q;
				end else begin
					frame_n    = {item_s1.rx_byte, frame_q[FRAME_BITS-1:8]};
					byte_cnt_n = byte_cnt_q + 5'd1;
				end
			end else if (gap_q >= GAP_TICKS && item_s1.rx_byte == HEADER_BYTE) begin
				in_frame_n = 1'b1;
				byte_cnt_n = 5'd0;
			end
		end
	end

	assign fs_load  = !fs_q && (link_n == 16'd0);
	assign good_inc = good_q + 9'd1;

	always_comb begin
		fs_n   = fs_load ? 1'b1 : fs_q;
		led_n  = fs_load ? 1'b0 : led_q;
		good_n = good_q;
		if (frame_done) begin
			fs_n   = 1'b0;
			good_n = good_inc;
			if (good_inc == LED_ON_AT) begin
				led_n = 1'b1;
			end else if (good_inc >= LED_OFF_AT) begin
				led_n  = 1'b0;
				good_n = 9'd0;
			end
		end
	end

	for (genvar k = 0; k < SERVO_OUTPUTS; k++) begin : g_lane
		rcsfd_servo_lane u_lane (
			.setup      (setup_q[k]),
			.frame      (frame_q[DECODE_BITS-1:0]),
			.pulse      (pulse_q[k]),
			.fs_load    (fs_load),
			.frame_load (frame_done),
			.pulse_next (pulse_n[k])
		);
	end

	for (genvar k = 0; k < PULSE_FIELDS; k++) begin : g_field
		if (k < SERVO_OUTPUTS) begin : g_on
			assign pulse_field[k] = pulse_n[k];
		end else begin : g_off
			assign pulse_field[k] = PULSE_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SERVO_OUTPUTS; k++)
				setup_q[k] <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			for (int k = 0; k < SERVO_OUTPUTS; k++)
				if (k < PULSE_FIELDS && wr_index == 3'(k))
					setup_q[k] <= servo_setup_t'(wr_data);
			if (wr_index == REG_TIMEOUT)
				timeout_q <= wr_data[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			byte_cnt_q <= 5'd0;
			gap_q      <= 2'd0;
			link_q     <= 16'd0;
			fs_q       <= 1'b0;
			good_q     <= 9'd0;
			led_q      <= 1'b0;
			for (int k = 0; k < SERVO_OUTPUTS; k++)
				pulse_q[k] <= PULSE_OFF;
		end else if (advance) begin
			in_frame_q <= in_frame_n;
			byte_cnt_q <= byte_cnt_n;
			gap_q      <= gap_n;
			link_q     <= link_n;
			fs_q       <= fs_n;
			good_q     <= good_n;
			led_q      <= led_n;
			for (int k = 0; k < SERVO_OUTPUTS; k++)
				pulse_q[k] <= pulse_n[k];
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			frame_q <= frame_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (advance) begin
			out_q.pulse_zero     <= pulse_field[0];
			out_q.pulse_one      <= pulse_field[1];
			out_q.pulse_two      <= pulse_field[2];
			out_q.pulse_three    <= pulse_field[3];
			out_q.outputs_loaded <= fs_load || frame_done;
			out_q.failsafe_on    <= fs_n;
			out_q.led_on         <= led_n;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rcsfd_checker.sv @@
// ----------------------------------------------------------------------------
// rcsfd_checker: port-level checks of the serial RC frame decoder
// Watches the handshake and result beats; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_checker
	import rcsfd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_fs_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.failsafe_on |-> !out_data.led_on)
		else $error("LED lit during failsafe");

	a_pulse_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pulse_zero == 12'd0 || out_data.pulse_zero[11])
			&& (out_data.pulse_one == 12'd0 || out_data.pulse_one[11])
			&& (out_data.pulse_two == 12'd0 || out_data.pulse_two[11])
			&& (out_data.pulse_three == 12'd0 || out_data.pulse_three[11]))
		else $error("pulse value neither off nor in drive range");

endmodule

bind rc_serial_frame_servo_decoder_unit rcsfd_checker u_rcsfd_checker (.*);

`default_nettype wire
